### hw/rtl/das_pkg.sv
// Shared types and constants of the damped angle smoother.
// Used by das_div, das_mul and damped_angle_smoother_core; no dependencies.
package das_pkg;

	// Serial divider and multiplier sizes
	localparam int DIV_NW = 60;
	localparam int DIV_DW = 42;
	localparam int MUL_AW = 52;
	localparam int MUL_BW = 34;
	localparam int CNT_W  = 6;

	// Register indexes
	localparam logic [1:0] REG_AIM    = 2'd0;
	localparam logic [1:0] REG_ROAM   = 2'd1;
	localparam logic [1:0] REG_MAXSPD = 2'd2;

	// Reset values of the registers
	localparam logic [9:0]  AIM_RST    = 10'd90;
	localparam logic [9:0]  ROAM_RST   = 10'd220;
	localparam logic [11:0] MAXSPD_RST = 12'd1400;

	// Angle and coefficient constants
	localparam int HALF_TURN = 11520;
	localparam int FULL_TURN = 23040;
	localparam int K_QUAD    = 31457;
	localparam int K_CUBE    = 15401;
	localparam int VEL_MAX   = 8388607;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_X,
		ST_X2,
		ST_X3,
		ST_KQ,
		ST_KC,
		ST_EX,
		ST_MC,
		ST_ERR,
		ST_PV,
		ST_SD,
		ST_TQ,
		ST_TW,
		ST_D2,
		ST_MV,
		ST_MR,
		ST_WC,
		ST_WR,
		ST_OUT
	} das_state_t;

	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  nbits;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} das_div_req_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} das_mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} das_unit_sts_t;

endpackage

### hw/rtl/das_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on das_pkg. The numerator arrives left-aligned; nbits sets the step count.
module das_div import das_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  das_div_req_t      req,
	output das_unit_sts_t     sts,
	output logic [DIV_NW-1:0] quo,
	output logic [DIV_DW-1:0] rem
);

	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   r_sh;
	logic [DIV_DW+1:0] dif;
	logic              ge;

	// Shift in the next numerator bit and trial-subtract
	always_comb begin
		r_sh = {r_q, q_q[DIV_NW-1]};
		dif  = {1'b0, r_sh} - {2'b00, den_q};
		ge   = !dif[DIV_DW+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num;
			r_q   <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			r_q <= ge ? dif[DIV_DW-1:0] : r_sh[DIV_DW-1:0];
			q_q <= {q_q[DIV_NW-2:0], ge};
		end
	end

	assign sts = '{busy: busy_q, done: done_q};
	assign quo = q_q;
	assign rem = r_q;

endmodule

### hw/rtl/das_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on das_pkg. Runs over every bit of the multiplier after start.
module das_mul import das_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  das_mul_req_t             req,
	output das_unit_sts_t            sts,
	output logic [MUL_AW+MUL_BW-1:0] prod
);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_AW:0]   hi_q;
	logic [MUL_BW-1:0] lo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_AW:0]   sum;

	// Add the multiplicand when the current multiplier bit is set
	always_comb begin
		sum = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MUL_BW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			hi_q <= '0;
			lo_q <= req.b;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[MUL_AW:1]};
			lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
		end
	end

	assign sts  = '{busy: busy_q, done: done_q};
	assign prod = {hi_q[MUL_AW-1:0], lo_q};

endmodule

### hw/rtl/damped_angle_smoother_core.sv
// Damped angle smoother: top level with sequencer and per-axis datapath.
// Depends on das_pkg, das_div and das_mul.
//
// Usage:
// A request on s_axis carries target pitch and yaw, the frame time and two
// flags (aim time select, restart). Each request produces exactly one result
// on m_axis holding the smoothed pitch and yaw. Smooth times and the speed
// limit are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// One request is worked on at a time; s_axis_tready is high only when the
// sequencer is idle. The bit-serial divider (one quotient bit per cycle, up
// to 60 bits per division) and the bit-serial multiplier are shared by the
// coefficient steps and the steps of both axes.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds the sequencer at its last step.
// Reset clears view angles and velocities to zero, loads the register reset
// values (aim 90 ms, roam 220 ms, 1400 deg/s) and empties the output register.
module damped_angle_smoother_core import das_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // target_pitch, target_yaw, frame_ms, zero pad
	input  logic [1:0]  s_axis_tuser,  // use_aim_time, restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // view_pitch, view_yaw, zero pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	das_state_t state_q, state_d;

	// Configuration
	logic [9:0]  aim_q;
	logic [9:0]  roam_q;
	logic [11:0] maxspd_q;

	// Axis state
	logic signed [14:0] view_q [2];
	logic signed [23:0] vel_q  [2];

	// Per-request values
	logic [9:0]         t_q;
	logic [7:0]         dt_q;
	logic signed [14:0] tgt_q [2];
	logic               axis_q;
	logic               run_q;

	// Shared coefficients
	logic [24:0] x_q;
	logic [33:0] x2_q;
	logic [42:0] x3_q;
	logic [41:0] den_q;
	logic [32:0] ex_q;
	logic [18:0] maxc_q;

	// Per-axis intermediates
	logic signed [14:0] e_q;
	logic signed [35:0] s_q;
	logic [42:0]        nmag_q;
	logic               sneg_q;
	logic [19:0]        dv_q;
	logic [39:0]        tqm_q;
	logic               tneg_q;
	logic [51:0]        w_q;
	logic [51:0]        imag_q;
	logic               ineg_q;
	logic signed [26:0] sum_q;
	logic [25:0]        wm_q;
	logic               wneg_q;

	// Output register
	logic        m_valid_q;
	logic [14:0] out_pitch_q;
	logic [14:0] out_yaw_q;

	// Units
	das_div_req_t            div_req;
	das_unit_sts_t           div_sts;
	logic [DIV_NW-1:0]       div_quo;
	logic [DIV_DW-1:0]       div_rem;
	das_mul_req_t            mul_req;
	das_unit_sts_t           mul_sts;
	logic [MUL_AW+MUL_BW-1:0] mul_prod;

	// Combinational helpers
	logic                     accept;
	logic                     out_load;
	logic [9:0]               t_sel;
	logic signed [14:0]       view_cur;
	logic signed [23:0]       vel_cur;
	logic signed [16:0]       d_raw;
	logic signed [16:0]       d_wr;
	logic signed [19:0]       d_ext;
	logic signed [19:0]       mx;
	logic signed [19:0]       e_c;
	logic signed [34:0]       vt;
	logic signed [35:0]       s_next;
	logic [35:0]              s_mag;
	logic signed [40:0]       tq_s;
	logic signed [41:0]       er;
	logic                     er_neg;
	logic [41:0]              er_mag;
	logic signed [52:0]       q2_s;
	logic signed [52:0]       inner;
	logic [52:0]              inner_mag;
	logic [MUL_AW+MUL_BW-1:0] rnd;
	logic [37:0]              r_mag;
	logic [23:0]              r_sat;
	logic signed [26:0]       r_s;
	logic signed [15:0]       wrap_res;

	das_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	das_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	assign t_sel         = s_axis_tuser[0] ? aim_q : roam_q;
	assign view_cur      = view_q[axis_q];
	assign vel_cur       = vel_q[axis_q];

	// Error, travel, rounding and wrap arithmetic
	always_comb begin
		d_raw = {{2{view_cur[14]}}, view_cur} - {{2{tgt_q[axis_q][14]}}, tgt_q[axis_q]};
		if (d_raw > 17'sd11520) begin
			d_wr = d_raw - 17'sd23040;
		end else if (d_raw < -17'sd11520) begin
			d_wr = d_raw + 17'sd23040;
		end else begin
			d_wr = d_raw;
		end
		d_ext = {{3{d_wr[16]}}, d_wr};
		mx    = $signed({1'b0, maxc_q});
		if (d_ext > mx) begin
			e_c = mx;
		end else if (d_ext < -mx) begin
			e_c = -mx;
		end else begin
			e_c = d_ext;
		end

		vt     = $signed({{11{vel_cur[23]}}, vel_cur}) * $signed({25'b0, t_q});
		s_next = {vt[34], vt} + $signed({{21{e_q[14]}}, e_q}) * 36'sd2000;
		s_mag  = s_q[35] ? 36'(-s_q) : 36'(s_q);

		tq_s   = tneg_q ? -$signed({1'b0, tqm_q}) : $signed({1'b0, tqm_q});
		er     = $signed({{11{e_q[14]}}, e_q, 16'b0}) + {tq_s[40], tq_s};
		er_neg = er[41];
		er_mag = er_neg ? 42'(-er) : 42'(er);

		q2_s      = tneg_q ? -$signed({2'b00, div_quo[50:0]})
			: $signed({2'b00, div_quo[50:0]});
		inner     = $signed({{13{vel_cur[23]}}, vel_cur, 16'b0}) - q2_s;
		inner_mag = inner[52] ? 53'(-inner) : 53'(inner);

		rnd   = mul_prod + ((MUL_AW+MUL_BW)'(1) << 47);
		r_mag = rnd[85:48];
		r_sat = (r_mag > 38'(VEL_MAX)) ? 24'(VEL_MAX) : r_mag[23:0];
		r_s   = er_neg ? -$signed({1'b0, r_mag[25:0]}) : $signed({1'b0, r_mag[25:0]});

		wrap_res = wneg_q ? (16'sd11519 - $signed({1'b0, div_rem[14:0]}))
			: ($signed({1'b0, div_rem[14:0]}) - 16'sd11519);
	end

	// Unit operand selection
	always_comb begin
		div_req = '{start: 1'b0, nbits: '0, num: '0, den: '0};
		mul_req = '{start: 1'b0, a: '0, b: '0};
		unique case (state_q)
			ST_X: begin
				div_req = '{start: !run_q, nbits: CNT_W'(25),
					num: DIV_NW'(dt_q) << 52, den: DIV_DW'(t_q)};
			end
			ST_EX: begin
				div_req = '{start: !run_q, nbits: CNT_W'(49),
					num: DIV_NW'(1) << 59, den: den_q};
			end
			ST_MC: begin
				div_req = '{start: !run_q, nbits: CNT_W'(28),
					num: DIV_NW'(22'(maxspd_q) * 22'(t_q)) << 38,
					den: DIV_DW'(1000)};
			end
			ST_TQ: begin
				div_req = '{start: !run_q, nbits: CNT_W'(60),
					num: {1'b0, nmag_q, 16'b0} + DIV_NW'(dv_q[19:1]),
					den: DIV_DW'(dv_q)};
			end
			ST_D2: begin
				div_req = '{start: !run_q, nbits: CNT_W'(52),
					num: DIV_NW'(w_q) << 8, den: DIV_DW'(t_q)};
			end
			ST_WR: begin
				div_req = '{start: !run_q, nbits: CNT_W'(26),
					num: DIV_NW'(wm_q) << 34, den: DIV_DW'(FULL_TURN)};
			end
			ST_X2: mul_req = '{start: !run_q, a: MUL_AW'(x_q), b: MUL_BW'(x_q)};
			ST_X3: mul_req = '{start: !run_q, a: MUL_AW'(x2_q), b: MUL_BW'(x_q)};
			ST_KQ: mul_req = '{start: !run_q, a: MUL_AW'(x2_q), b: MUL_BW'(K_QUAD)};
			ST_KC: mul_req = '{start: !run_q, a: MUL_AW'(x3_q), b: MUL_BW'(K_CUBE)};
			ST_MV: mul_req = '{start: !run_q, a: imag_q, b: MUL_BW'(ex_q)};
			ST_MR: mul_req = '{start: !run_q, a: MUL_AW'(er_mag), b: MUL_BW'(ex_q)};
			default: ;
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_X;
			ST_X:    if (div_sts.done) state_d = ST_X2;
			ST_X2:   if (mul_sts.done) state_d = ST_X3;
			ST_X3:   if (mul_sts.done) state_d = ST_KQ;
			ST_KQ:   if (mul_sts.done) state_d = ST_KC;
			ST_KC:   if (mul_sts.done) state_d = ST_EX;
			ST_EX:   if (div_sts.done) state_d = ST_MC;
			ST_MC:   if (div_sts.done) state_d = ST_ERR;
			ST_ERR:  state_d = ST_PV;
			ST_PV:   state_d = ST_SD;
			ST_SD:   state_d = ST_TQ;
			ST_TQ:   if (div_sts.done) state_d = ST_TW;
			ST_TW:   state_d = ST_D2;
			ST_D2:   if (div_sts.done) state_d = ST_MV;
			ST_MV:   if (mul_sts.done) state_d = ST_MR;
			ST_MR:   if (mul_sts.done) state_d = ST_WC;
			ST_WC: begin
				priority if (sum_q > 27'sd11520 || sum_q < -27'sd11520) begin
					state_d = ST_WR;
				end else if (axis_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_ERR;
				end
			end
			ST_WR:   if (div_sts.done) state_d = axis_q ? ST_OUT : ST_ERR;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: config, axis state, unit handshake, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_q     <= AIM_RST;
			roam_q    <= ROAM_RST;
			maxspd_q  <= MAXSPD_RST;
			view_q[0] <= '0;
			view_q[1] <= '0;
			vel_q[0]  <= '0;
			vel_q[1]  <= '0;
			axis_q    <= 1'b0;
			run_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AIM:    aim_q    <= cfg_data[9:0];
					REG_ROAM:   roam_q   <= cfg_data[9:0];
					REG_MAXSPD: maxspd_q <= cfg_data;
					default: ;
				endcase
			end

			if (div_req.start || mul_req.start) begin
				run_q <= 1'b1;
			end else if (div_sts.done || mul_sts.done) begin
				run_q <= 1'b0;
			end

			// Restart loads the view and clears velocity
			if (accept) begin
				axis_q <= 1'b0;
				if (s_axis_tuser[1]) begin
					view_q[0] <= $signed(s_axis_tdata[14:0]);
					view_q[1] <= $signed(s_axis_tdata[29:15]);
					vel_q[0]  <= '0;
					vel_q[1]  <= '0;
				end
			end

			if (state_q == ST_MV && mul_sts.done) begin
				vel_q[axis_q] <= ineg_q ? -$signed(r_sat) : $signed(r_sat);
			end

			// Angle update, stored directly when in range or wrapped through the divider
			if (state_q == ST_WC && !(sum_q > 27'sd11520 || sum_q < -27'sd11520)) begin
				view_q[axis_q] <= sum_q[14:0];
				axis_q         <= 1'b1;
			end
			if (state_q == ST_WR && div_sts.done) begin
				view_q[axis_q] <= wrap_res[14:0];
				axis_q         <= 1'b1;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q      <= (t_sel == 10'd0) ? 10'd1 : t_sel;
			dt_q     <= s_axis_tdata[37:30];
			tgt_q[0] <= $signed(s_axis_tdata[14:0]);
			tgt_q[1] <= $signed(s_axis_tdata[29:15]);
		end
		unique case (state_q)
			ST_X:  if (div_sts.done) x_q <= div_quo[24:0];
			ST_X2: if (mul_sts.done) x2_q <= mul_prod[49:16];
			ST_X3: if (mul_sts.done) x3_q <= mul_prod[58:16];
			ST_KQ: begin
				if (mul_sts.done) begin
					den_q <= 42'(65536) + 42'(x_q) + 42'(mul_prod[49:16]);
				end
			end
			ST_KC: if (mul_sts.done) den_q <= den_q + 42'(mul_prod[57:16]);
			ST_EX: if (div_sts.done) ex_q <= div_quo[32:0];
			ST_MC: if (div_sts.done) maxc_q <= div_quo[18:0];
			ST_ERR: e_q <= e_c[14:0];
			ST_PV:  s_q <= s_next;
			ST_SD: begin
				nmag_q <= 43'(s_mag[34:0]) * 43'(dt_q);
				sneg_q <= s_q[35];
				dv_q   <= 20'(t_q) * 20'(1000);
			end
			ST_TQ: begin
				if (div_sts.done) begin
					tqm_q  <= div_quo[39:0];
					tneg_q <= sneg_q;
				end
			end
			ST_TW: w_q <= 52'(tqm_q) * 52'(2000) + 52'(t_q[9:1]);
			ST_D2: begin
				if (div_sts.done) begin
					imag_q <= inner_mag[51:0];
					ineg_q <= inner[52];
				end
			end
			ST_MR: begin
				if (mul_sts.done) begin
					sum_q <= $signed({{12{view_cur[14]}}, view_cur})
						- $signed({{12{e_q[14]}}, e_q}) + r_s;
				end
			end
			ST_WC: begin
				if (sum_q > 27'sd11520) begin
					wm_q   <= 26'(sum_q - 27'sd11521);
					wneg_q <= 1'b0;
				end else begin
					wm_q   <= 26'(-27'sd11521 - sum_q);
					wneg_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_pitch_q <= view_q[0];
			out_yaw_q   <= view_q[1];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, out_yaw_q, out_pitch_q};

`ifndef SYNTHESIS
	// The divider is started only when it is free
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

	// Only one shared unit finishes at a time
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_sts.done && mul_sts.done))
		else $error("divider and multiplier finished together");

	// One request in work at a time
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// A result appears only from the final step
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result valid without completing the sequence");
`endif

endmodule
